/* rtl/core/agc_pkg.sv */
// Package for the anagram group classifier.
// Holds the sizing constants, beat payload types, status codes and the
// controller/datapath handshake structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package agc_pkg;

    localparam int ALPHABET_SIZE    = 26;
    localparam int MAX_LETTER_COUNT = 63;
    localparam int MAX_GROUPS       = 64;

    // Field widths fixed by the interface.
    localparam int CODE_W   = 5;
    localparam int GROUP_W  = 6;
    localparam int STATUS_W = 2;

    // Derived storage widths.
    localparam int CNT_W  = $clog2(MAX_LETTER_COUNT + 1);
    localparam int SIG_W  = ALPHABET_SIZE * CNT_W;
    localparam int GRP_AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int USED_W = $clog2(MAX_GROUPS + 1);

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] letter_code;
        logic              has_letter;
        logic              word_end;
    } t_in_item;

    typedef struct packed {
        logic [GROUP_W-1:0]  group_index;
        logic                new_group;
        logic [STATUS_W-1:0] status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic count;   // an input beat is taken: count its letter
        logic start;   // word end taken: reset the search
        logic read;    // issue a signature read at the search address
        logic cmp;     // read data is valid: compare it
        logic inc;     // advance the search address
        logic commit;  // finish the word: store, report, clear counts
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;     // no group stored yet
        logic match;     // read signature equals current counts
        logic last;      // search address is the last stored group
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/anagram_group_classifier.sv */
// Top level of the anagram group classifier.
// Ties the controller (agc_ctrl) to the datapath (agc_dp); uses agc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Words arrive one letter per input beat; letter beats that do not end a
// word are taken every cycle while no search is running. A beat with
// word_end set starts a linear search of the stored group signatures, one
// stored group at a time (a registered RAM read, then a 26-way count
// compare). The search stops at the first matching group or after the last
// stored group, and is skipped when no group exists yet; input ready stays
// low once the word-end beat is taken, until its result is committed. Each
// word end yields one result beat from an output register, so the next
// word can start while that result waits; a further word end then holds
// in its last state until the result ahead of it is taken.
module anagram_group_classifier (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire agc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output agc_pkg::t_out_item      o_out_item
);

    agc_pkg::t_cmd cmd;
    agc_pkg::t_sts sts;

    agc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_word_end (i_in_item.word_end),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    agc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* rtl/core/agc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the group signature store.
`timescale 1ns / 1ps
`default_nettype none

module agc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/agc_ctrl.sv */
// Controller for the anagram group classifier: sequences the letter
// counting, the group search over the signature store and the final commit.
// Depends on agc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_word_end,
    input  wire agc_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output agc_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_COMP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.count  = accept;
        case (r_state)
            S_IDLE: begin
                if (accept && i_word_end) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.empty ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_COMP;
            end
            S_COMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.match || i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_DONE: begin
                // Hold here until the output register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/agc_dp.sv */
// Datapath for the anagram group classifier: letter count signature,
// signature store, comparator, group counter and output register.
// Depends on agc_pkg and agc_ram.
`timescale 1ns / 1ps
`default_nettype none

module agc_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire agc_pkg::t_in_item   i_in_item,
    input  wire agc_pkg::t_cmd       i_cmd,
    input  wire logic                i_out_ready,
    output agc_pkg::t_sts            o_sts,
    output logic                     o_out_valid,
    output agc_pkg::t_out_item       o_out_item
);

    logic [agc_pkg::ALPHABET_SIZE-1:0][agc_pkg::CNT_W-1:0] r_counts;
    logic [agc_pkg::ALPHABET_SIZE-1:0][agc_pkg::CNT_W-1:0] n_counts;
    logic                        r_ovf;
    logic                        n_ovf;
    logic [agc_pkg::USED_W-1:0]  r_used;
    logic [agc_pkg::GRP_AW-1:0]  r_addr;
    logic                        r_hit;
    logic [agc_pkg::GRP_AW-1:0]  r_hit_idx;
    logic                        r_out_valid;
    agc_pkg::t_out_item          r_out;
    agc_pkg::t_out_item          n_out;
    logic [agc_pkg::SIG_W-1:0]   rd_sig;
    logic                        full;
    logic                        store_new;

    // Letter counting; the search reads these counts, so the word-end
    // beat's own letter lands before the first compare.
    always_comb begin
        n_counts = r_counts;
        n_ovf    = r_ovf;
        if (i_cmd.count && i_in_item.has_letter) begin
            for (int k = 0; k < agc_pkg::ALPHABET_SIZE; k++) begin
                if (int'(i_in_item.letter_code) == k) begin
                    if (r_counts[k] == agc_pkg::CNT_W'(agc_pkg::MAX_LETTER_COUNT)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_counts[k] = r_counts[k] + agc_pkg::CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
            r_ovf    <= 1'b0;
        end else if (i_cmd.commit) begin
            r_counts <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_counts <= n_counts;
            r_ovf    <= n_ovf;
        end
    end

    assign full      = (r_used == agc_pkg::USED_W'(agc_pkg::MAX_GROUPS));
    assign store_new = i_cmd.commit && !r_hit && !full;

    agc_ram #(
        .WIDTH (agc_pkg::SIG_W),
        .DEPTH (agc_pkg::MAX_GROUPS)
    ) u_sig_ram (
        .i_clk   (i_clk),
        .i_we    (store_new),
        .i_waddr (r_used[agc_pkg::GRP_AW-1:0]),
        .i_wdata (r_counts),
        .i_re    (i_cmd.read),
        .i_raddr (r_addr),
        .o_rdata (rd_sig)
    );

    // Search bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_addr    <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
        end else begin
            if (i_cmd.start) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
            end else if (i_cmd.inc) begin
                r_addr <= r_addr + agc_pkg::GRP_AW'(1);
            end
            if (i_cmd.cmp && o_sts.match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_addr;
            end
            if (store_new) begin
                r_used <= r_used + agc_pkg::USED_W'(1);
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (r_hit) begin
            n_out.group_index = agc_pkg::GROUP_W'(r_hit_idx);
        end else if (!full) begin
            n_out.group_index = agc_pkg::GROUP_W'(r_used);
            n_out.new_group   = 1'b1;
        end
        if (!r_hit && full) begin
            n_out.status = agc_pkg::ST_FULL;
        end else if (r_ovf) begin
            n_out.status = agc_pkg::ST_SAT;
        end else begin
            n_out.status = agc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.empty    = (r_used == '0);
    assign o_sts.match    = (rd_sig == r_counts);
    assign o_sts.last     = ((agc_pkg::USED_W'(r_addr) + agc_pkg::USED_W'(1)) == r_used);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for anagram_group_classifier.
// Predicts group numbers from letter-count signatures and checks each output beat in order.
// Depends on agc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

    class group_tracker;
        logic [agc_pkg::CNT_W-1:0] letter_tally [agc_pkg::ALPHABET_SIZE];
        logic [agc_pkg::CNT_W-1:0] group_sig [agc_pkg::MAX_GROUPS][agc_pkg::ALPHABET_SIZE];
        int unsigned               groups_open;
        bit                        saturated;
        agc_pkg::t_out_item        expected_groups[$];
        int                        mismatches;
        int                        full_count;

        function new();
            foreach (letter_tally[k]) letter_tally[k] = '0;
            groups_open = 0;
            saturated   = 0;
            mismatches  = 0;
            full_count  = 0;
        endfunction

        // Updates the letter tally and, on a word end, queues the expected group.
        function void note_beat(agc_pkg::t_in_item it);
            agc_pkg::t_out_item res;
            bit                 hit;
            bit                 same;
            int unsigned        g;
            if (it.has_letter && it.letter_code < agc_pkg::ALPHABET_SIZE) begin
                if (letter_tally[it.letter_code] >= agc_pkg::MAX_LETTER_COUNT) begin
                    saturated = 1'b1;
                end else begin
                    letter_tally[it.letter_code] =
                        letter_tally[it.letter_code] + agc_pkg::CNT_W'(1);
                end
            end
            if (!it.word_end) return;

            res = '0;
            hit = 1'b0;
            for (g = 0; g < groups_open && !hit; g++) begin
                same = 1'b1;
                foreach (letter_tally[k]) begin
                    if (group_sig[g][k] != letter_tally[k]) same = 1'b0;
                end
                if (same) begin
                    hit = 1'b1;
                    res.group_index = agc_pkg::GROUP_W'(g);
                end
            end
            if (!hit) begin
                if (groups_open < agc_pkg::MAX_GROUPS) begin
                    group_sig[groups_open] = letter_tally;
                    res.group_index = agc_pkg::GROUP_W'(groups_open);
                    res.new_group = 1'b1;
                    groups_open++;
                end else begin
                    res.status = agc_pkg::ST_FULL;
                    full_count++;
                end
            end
            if (res.status == agc_pkg::ST_OK && saturated) res.status = agc_pkg::ST_SAT;
            expected_groups = {expected_groups, res};

            foreach (letter_tally[k]) letter_tally[k] = '0;
            saturated = 1'b0;
        endfunction

        task report_mismatch(string msg);
            $display("check failed at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(agc_pkg::t_out_item got);
            agc_pkg::t_out_item want;
            if (expected_groups.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %p", got));
                return;
            end
            want = expected_groups.pop_front();
            if (got.group_index !== want.group_index)
                report_mismatch($sformatf("group_index %0d, predicted %0d",
                                          got.group_index, want.group_index));
            if (got.new_group !== want.new_group)
                report_mismatch($sformatf("new_group %0b, predicted %0b",
                                          got.new_group, want.new_group));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, predicted %0d",
                                          got.status, want.status));
        endtask
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    agc_pkg::t_in_item  in_item   = '0;
    logic               in_ready;
    logic               out_valid;
    logic               out_ready = 1'b0;
    agc_pkg::t_out_item out_item;

    group_tracker sb = new();

    int tx_pct   = 0;
    int rx_pct   = 0;
    bit hold_req = 1'b0;

    bit [5:0][4:0] lib_words[$];
    int            lib_lens[$];

    anagram_group_classifier DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // Output side: checks accepted beats and plays the receiver, including one long hold-off.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_result(out_item);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(rx_pct != 0 && $urandom_range(0, 99) < rx_pct);
            end
        end
    end

    function automatic agc_pkg::t_in_item mk_beat(int code, bit has, bit last);
        agc_pkg::t_in_item it;
        it.letter_code = agc_pkg::CODE_W'(code);
        it.has_letter  = has;
        it.word_end    = last;
        return it;
    endfunction

    // Valid is left high after acceptance so back-to-back beats never toggle it.
    task automatic send_beat(agc_pkg::t_in_item it);
        int gap;
        gap = 0;
        if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_beat(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_groups.size() != 0);
    endtask

    // Sends one word; noisy words carry ignored beats between letters.
    task automatic send_word(bit [5:0][4:0] w, int n, bit noisy, ref int items);
        bit split_end;
        split_end = (n == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 99) < 30) begin
                if ($urandom_range(0, 1)) send_beat(mk_beat($urandom_range(0, 31), 1'b0, 1'b0));
                else send_beat(mk_beat($urandom_range(agc_pkg::ALPHABET_SIZE, 31), 1'b1, 1'b0));
            end
            send_beat(mk_beat(w[i], 1'b1, !split_end && i == n - 1));
        end
        if (split_end) send_beat(mk_beat($urandom_range(0, 31), 1'b0, 1'b1));
        items += n + (split_end ? 1 : 0);
    endtask

    task automatic send_saturating(int letter, ref int items);
        int run;
        run = $urandom_range(agc_pkg::MAX_LETTER_COUNT + 1, agc_pkg::MAX_LETTER_COUNT + 7);
        for (int i = 0; i < run; i++) send_beat(mk_beat(letter, 1'b1, i == run - 1));
        items += run;
    endtask

    initial begin : stimulus
        int            items;
        int            word_no;
        int            pick;
        int            n;
        int            idx;
        int            j;
        int            sat_letter;
        int            sat_late;
        bit [4:0]      tmp;
        bit [5:0][4:0] w;

        items    = 0;
        word_no  = 0;
        sat_late = 0;
        sat_letter = $urandom_range(0, agc_pkg::ALPHABET_SIZE - 1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: empty word, extreme codes, ignored out-of-range letters,
        // anagrams, and a word end beat that carries no letter.
        send_beat(mk_beat(0, 1'b0, 1'b1));
        send_beat(mk_beat(31, 1'b0, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b1));
        send_beat(mk_beat(25, 1'b1, 1'b1));
        send_beat(mk_beat(31, 1'b1, 1'b1));
        send_beat(mk_beat(26, 1'b1, 1'b0));
        send_beat(mk_beat(0, 1'b1, 1'b1));
        send_beat(mk_beat(0, 1'b1, 1'b0));
        send_beat(mk_beat(1, 1'b1, 1'b1));
        send_beat(mk_beat(1, 1'b1, 1'b0));
        send_beat(mk_beat(0, 1'b1, 1'b1));
        send_beat(mk_beat(25, 1'b0, 1'b0));
        send_beat(mk_beat(25, 1'b1, 1'b1));
        send_beat(mk_beat(25, 1'b1, 1'b0));
        send_beat(mk_beat(25, 1'b1, 1'b0));
        send_beat(mk_beat(0, 1'b0, 1'b1));
        send_beat(mk_beat(31, 1'b0, 1'b0));
        send_beat(mk_beat(16, 1'b1, 1'b1));
        wait_drained();

        // Random words until the item budget is spent and the table has overflowed a few times.
        while (items < 450 || sb.full_count < 6) begin
            case ((word_no / 12) % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 46; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 46; end
                default: begin tx_pct = 8; rx_pct = 8; end
            endcase
            if (word_no == 30) hold_req = 1'b1;
            if (word_no == 70) wait_drained();

            pick = $urandom_range(0, 99);
            if (word_no == 8) begin
                send_saturating(sat_letter, items);
            end else if (sb.groups_open == agc_pkg::MAX_GROUPS && sat_late < 2) begin
                // Same letter again matches its stored group; another letter finds the table full.
                send_saturating((sat_letter + sat_late) % agc_pkg::ALPHABET_SIZE, items);
                sat_late++;
            end else if (pick < 55 || lib_words.size() == 0) begin
                n = $urandom_range(1, 6);
                foreach (w[i]) w[i] = $urandom_range(0, agc_pkg::ALPHABET_SIZE - 1);
                lib_words = {lib_words, w};
                lib_lens  = {lib_lens, n};
                send_word(w, n, 1'b0, items);
            end else if (pick < 80) begin
                idx = $urandom_range(0, lib_words.size() - 1);
                w   = lib_words[idx];
                n   = lib_lens[idx];
                for (int i = n - 1; i > 0; i--) begin
                    j    = $urandom_range(0, i);
                    tmp  = w[i];
                    w[i] = w[j];
                    w[j] = tmp;
                end
                send_word(w, n, 1'b0, items);
            end else if (pick < 88) begin
                send_word('0, 0, 1'b0, items);
            end else begin
                n = $urandom_range(0, 6);
                foreach (w[i]) w[i] = $urandom_range(0, agc_pkg::ALPHABET_SIZE - 1);
                send_word(w, n, 1'b1, items);
            end
            word_no++;
        end

        wait_drained();
        repeat (150) @(posedge clk);
        if (sb.expected_groups.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_groups.size()));
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
